// File: hdl/assert_macros.svh
// Assertion macros for the checker module of the LED color buffer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rlbc_pkg.sv
// Shared types, constants and helper functions of the RGB LED crossfade buffer.
// No dependencies; used by the design modules and the testbench by scoped names.
package rlbc_pkg;

   localparam int NUM_LEDS      = 8;
   localparam int LEVEL_DIVISOR = 256;
   localparam int LEVEL_MAX     = 255;
   localparam int STORE_SIZE    = NUM_LEDS * 3;
   localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int COLOR_W       = 8;
   localparam int DIV_W         = 16;
   localparam int CNT_W         = $clog2(DIV_W);

   // Operation codes
   localparam logic [2:0] OP_SET      = 3'd0;
   localparam logic [2:0] OP_FADE_ONE = 3'd1;
   localparam logic [2:0] OP_FADE_ALL = 3'd2;
   localparam logic [2:0] OP_SET_ALL  = 3'd3;
   localparam logic [2:0] OP_RAW      = 3'd4;
   localparam logic [2:0] OP_READ     = 3'd5;

   // Channel register commands
   localparam logic [2:0] CHAN_HOLD = 3'd0;
   localparam logic [2:0] CHAN_RGB  = 3'd1;
   localparam logic [2:0] CHAN_ZERO = 3'd2;
   localparam logic [2:0] CHAN_READ = 3'd3;
   localparam logic [2:0] CHAN_FADE = 3'd4;

   // Store access commands
   localparam logic [2:0] MEM_NONE   = 3'd0;
   localparam logic [2:0] MEM_RD_ONE = 3'd1;
   localparam logic [2:0] MEM_WR_ONE = 3'd2;
   localparam logic [2:0] MEM_WR_ALL = 3'd3;
   localparam logic [2:0] MEM_WR_RAW = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic [2:0]         led_index;
      logic [4:0]         byte_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [7:0]         byte_value;
      logic [7:0]         strength;
   } rlbc_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] led_red;
      logic [COLOR_W-1:0] led_green;
      logic [COLOR_W-1:0] led_blue;
   } rlbc_rsp_type;

   typedef struct packed {
      logic              load_req;
      logic [2:0]        chan_op;
      logic [2:0]        mem_op;
      logic [1:0]        ch;
      logic [ADDR_W-1:0] addr;
      logic              div_long;
      logic              div_short;
   } rlbc_cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       led_ok;
      logic       pos_ok;
      logic       div_done;
   } rlbc_status_type;

   // LED that holds a byte position: pos / 3 for any 5-bit position.
   function automatic logic [3:0] div3(input logic [4:0] pos);
      logic [8:0] prod;
      prod = 9'(pos) * 9'd11;
      return prod[8:5];
   endfunction

   // First byte position of an LED.
   function automatic logic [5:0] mul3(input logic [3:0] led);
      return 6'({led, 1'b0}) + 6'(led);
   endfunction

endpackage

// File: hdl/rgb_led_buffer_crossfade_unit.sv
// Top level of the RGB LED color buffer with crossfade.
// Depends on rlbc_pkg, rlbc_ctrl, rlbc_datapath (and rlbc_divider below it).
//
//   channel    | ports                       | handshake
//   -----------+-----------------------------+------------------------------
//   request    | start, busy, req_item       | taken when start && !busy
//   response   | rsp_valid, rsp_item         | one-cycle strobe, no backpressure
//
// A bad index or an unused operation goes from decode straight to the strobe. Each color
// channel of a fade runs the shared divider twice (16 quotient bits, then 8); writes to the
// store move a byte a cycle, while each read waits for its data before the next is issued.
// busy stays high from the accept through the strobe cycle; the next transaction can be
// accepted in the cycle after the strobe. Synchronous reset clears the controller, divider
// control and the store's valid bits. The receiver cannot stall: each result shows once.
module rgb_led_buffer_crossfade_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rlbc_pkg::rlbc_req_type req_item,
   output logic                   rsp_valid,
   output rlbc_pkg::rlbc_rsp_type rsp_item
);

   rlbc_pkg::rlbc_cmd_type    cmd;
   rlbc_pkg::rlbc_status_type status;

   // Sequence each transaction: decode, store accesses, divider runs, strobe.
   rlbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold the store, the working color and the fade arithmetic.
   rlbc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// File: hdl/rlbc_divider.sv
// Shared restoring divider, one quotient bit per cycle, for the crossfade step.
// Depends on rlbc_pkg.
module rlbc_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      short_div,
   input  logic [rlbc_pkg::DIV_W-1:0] dividend,
   input  logic [rlbc_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [rlbc_pkg::DIV_W-1:0] quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [rlbc_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rlbc_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [rlbc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [rlbc_pkg::DIV_W-1:0]     den_ff, den_in;
   logic [rlbc_pkg::DIV_W:0]       shifted;
   logic [rlbc_pkg::DIV_W:0]       trial;
   logic                           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[rlbc_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         den_in  = divisor;
         if (short_div) begin
            // Narrow dividend: align it to the top and run only its bits.
            quo_in = {dividend[rlbc_pkg::COLOR_W-1:0],
                      (rlbc_pkg::DIV_W-rlbc_pkg::COLOR_W)'(0)};
            cnt_in = rlbc_pkg::CNT_W'(rlbc_pkg::COLOR_W - 1);
         end else begin
            quo_in = dividend;
            cnt_in = rlbc_pkg::CNT_W'(rlbc_pkg::DIV_W - 1);
         end
      end else if (busy_ff) begin
         rem_in = fits ? trial[rlbc_pkg::DIV_W-1:0] : shifted[rlbc_pkg::DIV_W-1:0];
         quo_in = {quo_ff[rlbc_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/rlbc_datapath.sv
// Datapath of the LED crossfade buffer: color store, channel registers,
// fade arithmetic around the shared divider. Depends on rlbc_pkg, rlbc_divider.
module rlbc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  rlbc_pkg::rlbc_cmd_type     cmd,
   input  rlbc_pkg::rlbc_req_type     req_item,
   output rlbc_pkg::rlbc_status_type  status,
   output rlbc_pkg::rlbc_rsp_type     rsp_item
);

   rlbc_pkg::rlbc_req_type             req_ff, req_in;
   logic [rlbc_pkg::ADDR_W-1:0]        base_ff, base_in;
   logic [rlbc_pkg::COLOR_W-1:0]       chan_ff [3];
   logic [rlbc_pkg::COLOR_W-1:0]       chan_in [3];
   logic [rlbc_pkg::COLOR_W-1:0]       rdata_ff;
   logic [rlbc_pkg::COLOR_W-1:0]       store_ff [rlbc_pkg::STORE_SIZE];
   logic                               valid_ff [rlbc_pkg::STORE_SIZE];

   logic [rlbc_pkg::ADDR_W-1:0]        addr;
   logic                               wr_en;
   logic [rlbc_pkg::COLOR_W-1:0]       wr_data;
   logic [rlbc_pkg::COLOR_W-1:0]       cur;
   logic [rlbc_pkg::COLOR_W-1:0]       target;
   logic [rlbc_pkg::COLOR_W:0]         diff;
   logic [rlbc_pkg::COLOR_W:0]         diff_neg;
   logic                               d_neg;
   logic [rlbc_pkg::COLOR_W-1:0]       d_mag;
   logic [rlbc_pkg::DIV_W-1:0]         div_dividend;
   logic [rlbc_pkg::DIV_W-1:0]         div_divisor;
   logic                               div_done;
   logic [rlbc_pkg::DIV_W-1:0]         div_quotient;
   logic [rlbc_pkg::COLOR_W+1:0]       sum;
   logic [rlbc_pkg::COLOR_W-1:0]       faded;

   // Request capture and first byte position of the addressed LED.
   always_comb begin
      req_in  = req_ff;
      base_in = base_ff;
      if (cmd.load_req) begin
         req_in = req_item;
         if (req_item.operation == rlbc_pkg::OP_RAW) begin
            base_in = rlbc_pkg::ADDR_W'(rlbc_pkg::mul3(rlbc_pkg::div3(req_item.byte_index)));
         end else begin
            base_in = rlbc_pkg::ADDR_W'(rlbc_pkg::mul3({1'b0, req_item.led_index}));
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      base_ff <= base_in;
   end

   // Channel under work and its target.
   always_comb begin
      case (cmd.ch)
         2'd0: begin
            cur    = chan_ff[0];
            target = req_ff.red;
         end
         2'd1: begin
            cur    = chan_ff[1];
            target = req_ff.green;
         end
         default: begin
            cur    = chan_ff[2];
            target = req_ff.blue;
         end
      endcase
   end

   // Quotient sign follows the sign of the difference; a zero difference
   // divides by one so the first quotient is the level divisor itself.
   always_comb begin
      diff     = {1'b0, target} - {1'b0, cur};
      diff_neg = '0 - diff;
      d_neg    = diff[rlbc_pkg::COLOR_W];
      d_mag    = d_neg ? diff_neg[rlbc_pkg::COLOR_W-1:0] : diff[rlbc_pkg::COLOR_W-1:0];
      if (cmd.div_long) begin
         div_dividend = rlbc_pkg::DIV_W'(rlbc_pkg::LEVEL_DIVISOR);
         div_divisor  = (d_mag == '0) ? rlbc_pkg::DIV_W'(1) : rlbc_pkg::DIV_W'(d_mag);
      end else begin
         div_dividend = rlbc_pkg::DIV_W'(req_ff.strength);
         div_divisor  = div_quotient;
      end
   end

   rlbc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_long | cmd.div_short),
      .short_div (cmd.div_short),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   // Apply the step and clamp to 0..LEVEL_MAX.
   always_comb begin
      if (d_neg) begin
         sum = {2'b00, cur} - {2'b00, div_quotient[rlbc_pkg::COLOR_W-1:0]};
      end else begin
         sum = {2'b00, cur} + {2'b00, div_quotient[rlbc_pkg::COLOR_W-1:0]};
      end
      if (sum[rlbc_pkg::COLOR_W+1]) begin
         faded = '0;
      end else if (sum > (rlbc_pkg::COLOR_W+2)'(rlbc_pkg::LEVEL_MAX)) begin
         faded = rlbc_pkg::COLOR_W'(rlbc_pkg::LEVEL_MAX);
      end else begin
         faded = sum[rlbc_pkg::COLOR_W-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_in[k] = chan_ff[k];
         case (cmd.chan_op)
            rlbc_pkg::CHAN_RGB: begin
               chan_in[k] = (k == 0) ? req_ff.red : ((k == 1) ? req_ff.green : req_ff.blue);
            end
            rlbc_pkg::CHAN_ZERO: begin
               chan_in[k] = '0;
            end
            rlbc_pkg::CHAN_READ: begin
               if (2'(k) == cmd.ch) chan_in[k] = rdata_ff;
            end
            rlbc_pkg::CHAN_FADE: begin
               if (2'(k) == cmd.ch) chan_in[k] = faded;
            end
            default: begin
               chan_in[k] = chan_ff[k];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         chan_ff[k] <= chan_in[k];
      end
   end

   // Store port: one access per cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_data = cur;
      case (cmd.mem_op)
         rlbc_pkg::MEM_RD_ONE: begin
            addr = base_ff + rlbc_pkg::ADDR_W'(cmd.ch);
         end
         rlbc_pkg::MEM_WR_ONE: begin
            addr  = base_ff + rlbc_pkg::ADDR_W'(cmd.ch);
            wr_en = 1'b1;
         end
         rlbc_pkg::MEM_WR_ALL: begin
            addr  = cmd.addr;
            wr_en = 1'b1;
         end
         rlbc_pkg::MEM_WR_RAW: begin
            addr    = rlbc_pkg::ADDR_W'(req_ff.byte_index);
            wr_en   = 1'b1;
            wr_data = req_ff.byte_value;
         end
         default: begin
            addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      rdata_ff <= valid_ff[addr] ? store_ff[addr] : '0;
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rlbc_pkg::STORE_SIZE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign status.operation = req_ff.operation;
   assign status.led_ok    = 32'(req_ff.led_index) < 32'(rlbc_pkg::NUM_LEDS);
   assign status.pos_ok    = 32'(req_ff.byte_index) < 32'(rlbc_pkg::STORE_SIZE);
   assign status.div_done  = div_done;

   assign rsp_item.led_red   = chan_ff[0];
   assign rsp_item.led_green = chan_ff[1];
   assign rsp_item.led_blue  = chan_ff[2];

endmodule

// File: hdl/rlbc_ctrl.sv
// Controller of the LED crossfade buffer: sequences store accesses and the
// divider per operation. Depends on rlbc_pkg.
module rlbc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rlbc_pkg::rlbc_status_type status,
   output rlbc_pkg::rlbc_cmd_type    cmd,
   output logic                      busy,
   output logic                      rsp_valid
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_RD_ISSUE = 4'd2;
   localparam logic [3:0] ST_RD_WAIT  = 4'd3;
   localparam logic [3:0] ST_DIV1     = 4'd4;
   localparam logic [3:0] ST_WAIT1    = 4'd5;
   localparam logic [3:0] ST_WAIT2    = 4'd6;
   localparam logic [3:0] ST_WR_ONE   = 4'd7;
   localparam logic [3:0] ST_WR_ALL   = 4'd8;
   localparam logic [3:0] ST_WR_RAW   = 4'd9;
   localparam logic [3:0] ST_DONE     = 4'd10;

   logic [3:0]                    state_ff, state_in;
   logic [1:0]                    ch_ff, ch_in;
   logic [rlbc_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic                          last_ch;

   assign last_ch = (ch_ff == 2'd2);

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      addr_in       = addr_ff;
      cmd           = '0;
      cmd.ch        = ch_ff;
      cmd.addr      = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               ch_in        = 2'd0;
               addr_in      = '0;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.operation)
               rlbc_pkg::OP_SET: begin
                  cmd.chan_op = status.led_ok ? rlbc_pkg::CHAN_RGB : rlbc_pkg::CHAN_ZERO;
                  state_in    = status.led_ok ? ST_WR_ONE : ST_DONE;
               end
               rlbc_pkg::OP_FADE_ONE, rlbc_pkg::OP_READ: begin
                  if (!status.led_ok) cmd.chan_op = rlbc_pkg::CHAN_ZERO;
                  state_in = status.led_ok ? ST_RD_ISSUE : ST_DONE;
               end
               rlbc_pkg::OP_FADE_ALL: begin
                  // Fade from black toward the target.
                  cmd.chan_op = rlbc_pkg::CHAN_ZERO;
                  state_in    = ST_DIV1;
               end
               rlbc_pkg::OP_SET_ALL: begin
                  cmd.chan_op = rlbc_pkg::CHAN_RGB;
                  state_in    = ST_WR_ALL;
               end
               rlbc_pkg::OP_RAW: begin
                  if (!status.pos_ok) cmd.chan_op = rlbc_pkg::CHAN_ZERO;
                  state_in = status.pos_ok ? ST_WR_RAW : ST_DONE;
               end
               default: begin
                  cmd.chan_op = rlbc_pkg::CHAN_ZERO;
                  state_in    = ST_DONE;
               end
            endcase
         end
         ST_RD_ISSUE: begin
            cmd.mem_op = rlbc_pkg::MEM_RD_ONE;
            state_in   = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.chan_op = rlbc_pkg::CHAN_READ;
            if (last_ch) begin
               ch_in    = 2'd0;
               state_in = (status.operation == rlbc_pkg::OP_FADE_ONE) ? ST_DIV1 : ST_DONE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_RD_ISSUE;
            end
         end
         ST_DIV1: begin
            cmd.div_long = 1'b1;
            state_in     = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (status.div_done) begin
               cmd.div_short = 1'b1;
               state_in      = ST_WAIT2;
            end
         end
         ST_WAIT2: begin
            if (status.div_done) begin
               cmd.chan_op = rlbc_pkg::CHAN_FADE;
               if (last_ch) begin
                  ch_in    = 2'd0;
                  addr_in  = '0;
                  state_in = (status.operation == rlbc_pkg::OP_FADE_ONE) ? ST_WR_ONE : ST_WR_ALL;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_DIV1;
               end
            end
         end
         ST_WR_ONE: begin
            cmd.mem_op = rlbc_pkg::MEM_WR_ONE;
            if (last_ch) begin
               ch_in    = 2'd0;
               state_in = ST_DONE;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_WR_ALL: begin
            cmd.mem_op = rlbc_pkg::MEM_WR_ALL;
            ch_in      = last_ch ? 2'd0 : ch_ff + 2'd1;
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == rlbc_pkg::ADDR_W'(rlbc_pkg::STORE_SIZE - 1)) begin
               ch_in    = 2'd0;
               addr_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_WR_RAW: begin
            cmd.mem_op = rlbc_pkg::MEM_WR_RAW;
            ch_in      = 2'd0;
            state_in   = ST_RD_ISSUE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 2'd0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         addr_ff  <= addr_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// File: hdl/rlbc_checker.sv
// Port-level checker for the LED crossfade buffer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rlbc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   `ASSERT_IMPLIES(a_strobe_while_busy, clock, reset, rsp_valid, busy, "strobe outside a transaction")
   `ASSERT_NEXT(a_strobe_ends_work, clock, reset, rsp_valid, !rsp_valid && !busy, "strobe not final")
   `ASSERT_NEXT(a_idle_stays_quiet, clock, reset, !busy && !start, !busy && !rsp_valid, "idle woke up")

endmodule

bind rgb_led_buffer_crossfade_unit rlbc_checker u_checker (.*);

// File: tb/rgb_led_buffer_crossfade_unit_tb.sv
// Self-checking testbench for rgb_led_buffer_crossfade_unit: directed and random transactions.
// Depends on rlbc_pkg and the RTL of the block; keeps its own copy of the LED color store.
module rgb_led_buffer_crossfade_unit_tb;

   // Codes that the package leaves unnamed: both must leave the store alone.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Slowest transaction is fade all; allow a wide margin.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int TOTAL_ITEMS    = 1100;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   rlbc_pkg::rlbc_req_type req_item;
   logic                   rsp_valid;
   rlbc_pkg::rlbc_rsp_type rsp_item;

   // Model of the color store, three bytes per LED, red first.
   logic [7:0]             led_store [rlbc_pkg::STORE_SIZE];
   rlbc_pkg::rlbc_rsp_type expected_colors [$];

   bit gaps_on;
   int items_sent;
   int results_checked;
   int error_count;
   int idle_cycles;
   int op_count [8];

   rgb_led_buffer_crossfade_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Color prediction
   // ---------------------------------------------------------------------------

   // One crossfade step of a channel from its current value toward a target.
   // Both divisions are signed and truncate toward zero, as int division does.
   function automatic logic [7:0] fade_step(input int cur, input int tgt, input int str);
      int diff;
      int quot;
      int val;
      diff = tgt - cur;
      quot = rlbc_pkg::LEVEL_DIVISOR;
      if (diff != 0) begin
         quot = rlbc_pkg::LEVEL_DIVISOR / diff;
      end
      if (quot == 0) begin
         quot = 1;
      end
      val = cur + str / quot;
      if (val > rlbc_pkg::LEVEL_MAX) begin
         val = rlbc_pkg::LEVEL_MAX;
      end
      if (val < 0) begin
         val = 0;
      end
      return 8'(val);
   endfunction

   // Apply one accepted transaction to the store model; return the color it shows.
   function automatic rlbc_pkg::rlbc_rsp_type advance_store(input rlbc_pkg::rlbc_req_type item);
      rlbc_pkg::rlbc_rsp_type shown;
      logic [7:0]             r;
      logic [7:0]             g;
      logic [7:0]             b;
      int                     base;
      shown = '0;
      r = item.red;
      g = item.green;
      b = item.blue;
      case (item.operation)
         rlbc_pkg::OP_SET, rlbc_pkg::OP_FADE_ONE, rlbc_pkg::OP_READ: begin
            if (int'(item.led_index) < rlbc_pkg::NUM_LEDS) begin
               base = 3 * int'(item.led_index);
               if (item.operation == rlbc_pkg::OP_SET) begin
                  led_store[base]     = r;
                  led_store[base + 1] = g;
                  led_store[base + 2] = b;
               end else if (item.operation == rlbc_pkg::OP_FADE_ONE) begin
                  led_store[base]     = fade_step(led_store[base], r, item.strength);
                  led_store[base + 1] = fade_step(led_store[base + 1], g, item.strength);
                  led_store[base + 2] = fade_step(led_store[base + 2], b, item.strength);
               end
               shown = {led_store[base], led_store[base + 1], led_store[base + 2]};
            end
         end
         rlbc_pkg::OP_FADE_ALL, rlbc_pkg::OP_SET_ALL: begin
            // Fade all always starts from black, not from the stored color.
            if (item.operation == rlbc_pkg::OP_FADE_ALL) begin
               r = fade_step(0, r, item.strength);
               g = fade_step(0, g, item.strength);
               b = fade_step(0, b, item.strength);
            end
            for (int n = 0; n < rlbc_pkg::NUM_LEDS; n++) begin
               led_store[3 * n]     = r;
               led_store[3 * n + 1] = g;
               led_store[3 * n + 2] = b;
            end
            shown = {r, g, b};
         end
         rlbc_pkg::OP_RAW: begin
            if (int'(item.byte_index) < rlbc_pkg::STORE_SIZE) begin
               led_store[item.byte_index] = item.byte_value;
               base = 3 * (int'(item.byte_index) / 3);
               shown = {led_store[base], led_store[base + 1], led_store[base + 2]};
            end
         end
         default: ;
      endcase
      return shown;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Idle time before a transaction: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (!gaps_on) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 45) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(3, 1);
      end else if (roll < 97) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(80, 20);
   endfunction

   function automatic logic [2:0] pick_operation();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         return rlbc_pkg::OP_SET;
      end else if (roll < 40) begin
         return rlbc_pkg::OP_FADE_ONE;
      end else if (roll < 48) begin
         return rlbc_pkg::OP_FADE_ALL;
      end else if (roll < 54) begin
         return rlbc_pkg::OP_SET_ALL;
      end else if (roll < 70) begin
         return rlbc_pkg::OP_RAW;
      end else if (roll < 94) begin
         return rlbc_pkg::OP_READ;
      end
      return ($urandom_range(1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
   endfunction

   // Strength biased toward the ends, where the divider result is most fragile.
   function automatic logic [7:0] pick_strength();
      int roll;
      roll = $urandom_range(9);
      if (roll < 2) begin
         return 8'd255;
      end else if (roll < 3) begin
         return 8'($urandom_range(3));
      end
      return 8'($urandom_range(255));
   endfunction

   // Random contents for every field; raw writes mostly land inside the store.
   function automatic rlbc_pkg::rlbc_req_type fill_item(input logic [2:0] op);
      rlbc_pkg::rlbc_req_type item;
      item.operation  = op;
      item.led_index  = 3'($urandom_range(7));
      if (op == rlbc_pkg::OP_RAW && $urandom_range(99) < 85) begin
         item.byte_index = 5'($urandom_range(rlbc_pkg::STORE_SIZE - 1));
      end else begin
         item.byte_index = 5'($urandom_range(31));
      end
      item.red        = 8'($urandom_range(255));
      item.green      = 8'($urandom_range(255));
      item.blue       = 8'($urandom_range(255));
      item.byte_value = 8'($urandom_range(255));
      item.strength   = 8'($urandom_range(255));
      return item;
   endfunction

   // Send one transaction. Called and returns at a falling edge; start stays
   // high on return so back-to-back transactions need not drop start between them.
   task automatic send_item(input rlbc_pkg::rlbc_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      // Hold until the block takes it; busy only changes at a rising edge.
      do begin
         @(posedge clock);
      end while (busy);
      expected_colors.push_back(advance_store(item));
      items_sent++;
      op_count[item.operation]++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checking: every strobe is one result, matched in order
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rlbc_pkg::rlbc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_colors.size() == 0) begin
            $error("result with no transaction outstanding: %0d %0d %0d",
                   rsp_item.led_red, rsp_item.led_green, rsp_item.led_blue);
            error_count++;
         end else begin
            want = expected_colors.pop_front();
            check_field("led_red", want.led_red, rsp_item.led_red);
            check_field("led_green", want.led_green, rsp_item.led_green);
            check_field("led_blue", want.led_blue, rsp_item.led_blue);
            results_checked++;
         end
      end
   end

   // Abort when neither side moves for too long (hung block or lost result).
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_colors.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Store comes out of reset black: read the first and last LED.
   task automatic test_reset_black();
      rlbc_pkg::rlbc_req_type item;
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = 3'd0;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = 3'(rlbc_pkg::NUM_LEDS - 1);
      send_item(item);
   endtask

   // One pass through every operation with extreme field values.
   task automatic test_each_operation();
      rlbc_pkg::rlbc_req_type item;
      item = fill_item(rlbc_pkg::OP_SET);
      item.led_index = 3'd3;
      {item.red, item.green, item.blue} = {8'd255, 8'd0, 8'd128};
      send_item(item);
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = 3'd3;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ONE);
      item.led_index = 3'd3;
      {item.red, item.green, item.blue} = {8'd0, 8'd255, 8'd128};
      item.strength = 8'd255;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ALL);
      {item.red, item.green, item.blue} = {8'd255, 8'd255, 8'd255};
      item.strength = 8'd255;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ALL);
      item.strength = 8'd0;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_SET_ALL);
      {item.red, item.green, item.blue} = {8'h55, 8'hAA, 8'hFF};
      send_item(item);
      item = fill_item(rlbc_pkg::OP_RAW);
      item.byte_index = 5'd0;
      item.byte_value = 8'hFF;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_RAW);
      item.byte_index = 5'(rlbc_pkg::STORE_SIZE - 1);
      item.byte_value = 8'h00;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = 3'(rlbc_pkg::NUM_LEDS - 1);
      send_item(item);
   endtask

   // Fade corner cases: full swing up and down, zero difference, unit difference.
   task automatic test_fade_extremes();
      rlbc_pkg::rlbc_req_type item;
      item = fill_item(rlbc_pkg::OP_SET);
      item.led_index = 3'd1;
      {item.red, item.green, item.blue} = '0;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ONE);
      item.led_index = 3'd1;
      {item.red, item.green, item.blue} = {8'd255, 8'd255, 8'd0};
      item.strength = 8'd255;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ONE);
      item.led_index = 3'd1;
      {item.red, item.green, item.blue} = {8'd0, 8'd255, 8'd255};
      item.strength = 8'd255;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_SET);
      item.led_index = 3'd1;
      {item.red, item.green, item.blue} = {8'd10, 8'd200, 8'd128};
      send_item(item);
      item = fill_item(rlbc_pkg::OP_FADE_ONE);
      item.led_index = 3'd1;
      {item.red, item.green, item.blue} = {8'd11, 8'd199, 8'd128};
      item.strength = 8'd255;
      send_item(item);
   endtask

   // Raw writes past the end of the store and the two unused codes must change
   // nothing and show black. An LED index past the end cannot be encoded with
   // eight LEDs and a 3-bit index.
   task automatic test_ignored_transactions();
      rlbc_pkg::rlbc_req_type item;
      item = fill_item(rlbc_pkg::OP_RAW);
      item.byte_index = 5'(rlbc_pkg::STORE_SIZE);
      send_item(item);
      item = fill_item(rlbc_pkg::OP_RAW);
      item.byte_index = 5'd31;
      item.byte_value = 8'hFF;
      send_item(item);
      item = fill_item(OP_SPARE_6);
      send_item(item);
      item = fill_item(OP_SPARE_7);
      {item.red, item.green, item.blue, item.strength} = '1;
      send_item(item);
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = 3'(rlbc_pkg::NUM_LEDS - 1);
      send_item(item);
   endtask

   // A realistic fade: mostly seed the LED (alone or with the whole store), step it toward a
   // fixed target several times, then read it back. A little noise keeps other LEDs moving.
   task automatic run_fade_sequence();
      rlbc_pkg::rlbc_req_type item;
      logic [2:0]             led;
      logic [7:0]             tgt_r;
      logic [7:0]             tgt_g;
      logic [7:0]             tgt_b;
      int                     steps;
      int                     seed_kind;
      led   = 3'($urandom_range(rlbc_pkg::NUM_LEDS - 1));
      tgt_r = ($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom_range(255));
      tgt_g = ($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom_range(255));
      tgt_b = ($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom_range(255));
      steps = $urandom_range(8, 2);
      seed_kind = $urandom_range(3);
      if (seed_kind == 0) begin
         item = fill_item(rlbc_pkg::OP_SET);
         item.led_index = led;
         send_item(item);
      end else if (seed_kind == 1) begin
         item = fill_item(rlbc_pkg::OP_SET_ALL);
         send_item(item);
      end else if (seed_kind == 2) begin
         item = fill_item(rlbc_pkg::OP_FADE_ALL);
         send_item(item);
      end
      repeat (steps) begin
         if ($urandom_range(9) == 0) begin
            item = fill_item(pick_operation());
         end else begin
            item = fill_item(rlbc_pkg::OP_FADE_ONE);
            item.led_index = led;
            {item.red, item.green, item.blue} = {tgt_r, tgt_g, tgt_b};
            item.strength = pick_strength();
         end
         send_item(item);
      end
      item = fill_item(rlbc_pkg::OP_READ);
      item.led_index = led;
      send_item(item);
   endtask

   // Mostly fade sequences, the rest single random transactions of any code.
   // Idling switches off now and then to run stretches back to back.
   task automatic test_random_traffic(input int target);
      while (items_sent < target) begin
         if ($urandom_range(39) == 0) begin
            gaps_on = ($urandom_range(2) != 0);
         end
         if ($urandom_range(99) < 55) begin
            run_fade_sequence();
         end else begin
            send_item(fill_item(pick_operation()));
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      gaps_on         = 1'b1;
      items_sent      = 0;
      results_checked = 0;
      error_count     = 0;
      idle_cycles     = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (led_store[i]) led_store[i] = 8'd0;

      // Synchronous reset, released at a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_black();
      test_each_operation();
      test_fade_extremes();
      test_ignored_transactions();
      test_random_traffic(TOTAL_ITEMS);

      // Drop start, wait out every outstanding result, then watch for strays.
      start <= 1'b0;
      while (expected_colors.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions and compared %0d results with the store model.",
               items_sent, results_checked);
      $display({"Mix: set %0d, fade one %0d, fade all %0d, set all %0d, ",
                "raw %0d, read %0d, unused %0d"},
               op_count[rlbc_pkg::OP_SET], op_count[rlbc_pkg::OP_FADE_ONE],
               op_count[rlbc_pkg::OP_FADE_ALL], op_count[rlbc_pkg::OP_SET_ALL],
               op_count[rlbc_pkg::OP_RAW], op_count[rlbc_pkg::OP_READ],
               op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
      if (error_count == 0 && expected_colors.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/rlbc_pkg.sv
hdl/rlbc_divider.sv
hdl/rlbc_datapath.sv
hdl/rlbc_ctrl.sv
hdl/rgb_led_buffer_crossfade_unit.sv
hdl/rlbc_checker.sv
tb/rgb_led_buffer_crossfade_unit_tb.sv
